// File: design/sjs_pkg.sv
// Shared constants, stratum tables and reciprocal table for the sample generator.
package sjs_pkg;

  localparam int unsigned MaxSampleCount = 1024;
  localparam int unsigned FracBits       = 24;
  localparam int unsigned CountW         = 11;
  localparam int unsigned ColW           = 6;   // up to ceil(sqrt(MaxSampleCount)) = 32
  localparam int unsigned PosW           = 5;
  localparam int unsigned DivNW          = 30;
  localparam int unsigned MaxCols        = 32;

  localparam logic [31:0] MixK1    = 32'h7FEB352D;
  localparam logic [31:0] MixK2    = 32'h846CA68B;
  localparam logic [31:0] HashInit = 32'h9E3779B9;
  localparam logic [31:0] SeedOfs  = 32'h85EBCA6B;
  localparam logic [31:0] IdxOfs   = 32'hC2B2AE35;
  localparam logic [31:0] CntOfs   = 32'h27D4EB2F;
  localparam logic [31:0] DimOfs   = 32'h165667B1;
  localparam logic [31:0] USalt    = 32'hA511E9B3;
  localparam logic [31:0] VSalt    = 32'h63D83595;

  localparam logic [FracBits-1:0] CoordCenter = FracBits'(1 << (FracBits - 1));
  localparam logic [FracBits-1:0] CoordMax    = {FracBits{1'b1}};
  localparam logic [63:0]         Two32       = 64'h1_0000_0000;

  // 16-entry 4x4 pattern, returns {x, y}
  function automatic logic [3:0] pat16(input logic [3:0] i);
    logic [3:0] r;
    unique case (i)
      4'd0:  r = {2'd0, 2'd0};
      4'd1:  r = {2'd2, 2'd0};
      4'd2:  r = {2'd1, 2'd1};
      4'd3:  r = {2'd3, 2'd1};
      4'd4:  r = {2'd0, 2'd2};
      4'd5:  r = {2'd2, 2'd2};
      4'd6:  r = {2'd1, 2'd3};
      4'd7:  r = {2'd3, 2'd3};
      4'd8:  r = {2'd1, 2'd0};
      4'd9:  r = {2'd3, 2'd0};
      4'd10: r = {2'd0, 2'd1};
      4'd11: r = {2'd2, 2'd1};
      4'd12: r = {2'd1, 2'd2};
      4'd13: r = {2'd3, 2'd2};
      4'd14: r = {2'd0, 2'd3};
      default: r = {2'd2, 2'd3};
    endcase
    return r;
  endfunction

  // floor(2^32 / d) for divisors 2..32; other codes return all ones
  function automatic logic [31:0] recip(input logic [ColW-1:0] d);
    logic [31:0] r;
    unique case (d)
      6'd2:  r = 32'(Two32 / 2);
      6'd3:  r = 32'(Two32 / 3);
      6'd4:  r = 32'(Two32 / 4);
      6'd5:  r = 32'(Two32 / 5);
      6'd6:  r = 32'(Two32 / 6);
      6'd7:  r = 32'(Two32 / 7);
      6'd8:  r = 32'(Two32 / 8);
      6'd9:  r = 32'(Two32 / 9);
      6'd10: r = 32'(Two32 / 10);
      6'd11: r = 32'(Two32 / 11);
      6'd12: r = 32'(Two32 / 12);
      6'd13: r = 32'(Two32 / 13);
      6'd14: r = 32'(Two32 / 14);
      6'd15: r = 32'(Two32 / 15);
      6'd16: r = 32'(Two32 / 16);
      6'd17: r = 32'(Two32 / 17);
      6'd18: r = 32'(Two32 / 18);
      6'd19: r = 32'(Two32 / 19);
      6'd20: r = 32'(Two32 / 20);
      6'd21: r = 32'(Two32 / 21);
      6'd22: r = 32'(Two32 / 22);
      6'd23: r = 32'(Two32 / 23);
      6'd24: r = 32'(Two32 / 24);
      6'd25: r = 32'(Two32 / 25);
      6'd26: r = 32'(Two32 / 26);
      6'd27: r = 32'(Two32 / 27);
      6'd28: r = 32'(Two32 / 28);
      6'd29: r = 32'(Two32 / 29);
      6'd30: r = 32'(Two32 / 30);
      6'd31: r = 32'(Two32 / 31);
      6'd32: r = 32'(Two32 / 32);
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// File: design/sjs_mix.sv
// Two-stage lowbias32 mixer: one multiply per register stage.
module sjs_mix (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] val_i,
  output logic [31:0] mix_o
);
  import sjs_pkg::*;

  logic [31:0] m1_q, m1_d, m2_q, m2_d;

  always_comb begin
    m1_d = 32'((val_i ^ (val_i >> 16)) * MixK1);
    m2_d = 32'((m1_q ^ (m1_q >> 15)) * MixK2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

  assign mix_o = m2_q ^ (m2_q >> 16);

endmodule

// File: design/sjs_div.sv
// Two-stage divider by a small divisor: reciprocal multiply, back-multiply, one fix-up.
module sjs_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [sjs_pkg::DivNW-1:0]   num_i,
  input  logic [sjs_pkg::ColW-1:0]    den_i,
  output logic [sjs_pkg::DivNW-1:0]   quo_o,
  output logic [sjs_pkg::ColW-1:0]    rem_o
);
  import sjs_pkg::*;

  logic [DivNW-1:0] n1_q, n2_q, q1_q, q2_q, p2_q, q1_d, p2_d, r;
  logic [ColW-1:0]  d1_q, d2_q;
  logic [DivNW+31:0] prod;
  logic              fix;

  always_comb begin
    prod = (DivNW+32)'(num_i) * (DivNW+32)'(recip(den_i));
    q1_d = prod[DivNW+31:32];
    p2_d = DivNW'(q1_q * DivNW'(d1_q));
    r    = n2_q - p2_q;
    fix  = r >= DivNW'(d2_q);
    quo_o = fix ? q2_q + DivNW'(1) : q2_q;
    rem_o = fix ? ColW'(r - DivNW'(d2_q)) : ColW'(r);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q <= num_i;
      d1_q <= den_i;
      q1_q <= q1_d;
      n2_q <= n1_q;
      d2_q <= d1_q;
      q2_q <= q1_q;
      p2_q <= p2_d;
    end
  end

endmodule

// File: design/stratified_jitter_sample_2d.sv
// Top level: pipelined stratified, optionally jittered 2D sample position generator.
//
// Input channel (in_valid_i / in_ready_o) carries seed, sample index and sample
// count; one transfer in gives exactly one transfer out on the result channel
// (out_valid_o / out_ready_i) with coord_u_o / coord_v_o in unsigned 0.24.
// The config channel (cfg_valid_i / cfg_ready_o) writes jitter_enable; it is
// always ready and must be written only while the pipeline is empty.
//
// Throughput is one item per cycle unless the receiver stalls. Nine register
// stages, each holding one multiply at most
// (the hash mixers, the reciprocal multiply and back-multiply of the dividers).
// Stage 1-2 mix seed, index and count; 2-3 the grid divider splits the index
// into column and row; 3-4 mix the combined hash while the stratum is picked;
// 5-6 mix the two jitter values; 7-8 divide the position by the stratum count;
// 9 is the output register.
//
// Reset clears the valid bits and jitter_enable; data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready_o drops, so nothing is lost or repeated; bubbles inside the pipe are
// not squeezed out during a stall, they advance with everything else.
module stratified_jitter_sample_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [31:0]                    base_seed_i,
  input  logic [15:0]                    sample_index_i,
  input  logic [sjs_pkg::CountW-1:0]     sample_count_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_jitter_enable_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sjs_pkg::FracBits-1:0]   coord_u_o,
  output logic [sjs_pkg::FracBits-1:0]   coord_v_o
);
  import sjs_pkg::*;

  localparam int unsigned Depth = 9;

  logic             en;
  logic [Depth-1:0] vld_q;
  logic             jit_q;

  // advance every stage together whenever the output slot can move
  assign en          = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      jit_q <= 1'b0;
    end else begin
      if (en) vld_q <= {vld_q[Depth-2:0], in_valid_i};
      if (cfg_valid_i) jit_q <= cfg_jitter_enable_i;
    end
  end

  // ---- stage 0 comb: clamp count, find grid columns
  logic [CountW-1:0] cnt0;
  logic [ColW-1:0]   cols0;
  logic              ctr0;

  always_comb begin
    if (sample_count_i > CountW'(MaxSampleCount)) cnt0 = CountW'(MaxSampleCount);
    else if (sample_count_i == '0) cnt0 = CountW'(1);
    else cnt0 = sample_count_i;
    ctr0  = cnt0 == CountW'(1);
    // ceil(sqrt(cnt)): the smallest c with c*c at or above cnt
    cols0 = ColW'(MaxCols);
    for (int c = MaxCols - 1; c >= 1; c--) begin
      if (CountW'(c * c) >= cnt0) cols0 = ColW'(c);
    end
  end

  // hash of the three inputs and the dimension constant
  logic [31:0] mix_s, mix_i, mix_c, mix_d;

  sjs_mix u_mix_seed (.clk_i, .en_i(en), .val_i(base_seed_i + SeedOfs), .mix_o(mix_s));
  sjs_mix u_mix_idx  (.clk_i, .en_i(en), .val_i(32'(sample_index_i) + IdxOfs), .mix_o(mix_i));
  sjs_mix u_mix_cnt  (.clk_i, .en_i(en), .val_i(32'(cnt0) + CntOfs), .mix_o(mix_c));
  sjs_mix u_mix_dim  (.clk_i, .en_i(en), .val_i(DimOfs), .mix_o(mix_d));

  // ---- stage 1 registers
  logic [CountW-1:0] cnt1_q, cnt2_q, cnt3_q;
  logic [15:0]       idx1_q, idx2_q, idx3_q;
  logic [ColW-1:0]   cols1_q, cols2_q, cols3_q;
  logic [ColW-1:0]   rows2_q, rows3_q;
  logic [ColW-1:0]   rows1;
  logic [CountW-1:0] gidx1;
  logic [Depth-1:0]  ctr_q;

  always_comb begin
    gidx1 = (idx1_q > 16'(cnt1_q - CountW'(1))) ? cnt1_q - CountW'(1) : CountW'(idx1_q);
    // rows is cols or cols-1 since (cols-1)^2 < cnt <= cols^2
    rows1 = (12'(cnt1_q) > 12'(cols1_q) * 12'(cols1_q - ColW'(1))) ? cols1_q
                                                                   : cols1_q - ColW'(1);
  end

  // grid divider: index into column (remainder) and row (quotient)
  logic [DivNW-1:0] gq;
  logic [ColW-1:0]  gr;

  sjs_div u_div_grid (
    .clk_i, .en_i(en), .num_i(DivNW'(gidx1)), .den_i(cols1_q), .quo_o(gq), .rem_o(gr)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctr_q   <= {ctr_q[Depth-2:0], ctr0};
      cnt1_q  <= cnt0;
      idx1_q  <= sample_index_i;
      cols1_q <= cols0;
      cnt2_q  <= cnt1_q;
      idx2_q  <= idx1_q;
      cols2_q <= cols1_q;
      rows2_q <= rows1;
      cnt3_q  <= cnt2_q;
      idx3_q  <= idx2_q;
      cols3_q <= cols2_q;
      rows3_q <= rows2_q;
    end
  end

  // ---- stage 3 comb: combined hash into the final mixer, pick the stratum
  logic [31:0] h_mix;

  sjs_mix u_mix_all (
    .clk_i, .en_i(en), .val_i(HashInit ^ mix_s ^ mix_i ^ mix_c ^ mix_d), .mix_o(h_mix)
  );

  logic [PosW-1:0] x3, y3;
  logic [ColW-1:0] nc3, nr3;
  logic [3:0]      p3;

  always_comb begin
    p3  = pat16((idx3_q > 16'd15) ? 4'd15 : idx3_q[3:0]);
    x3  = PosW'(p3[3:2]);
    y3  = PosW'(p3[1:0]);
    nc3 = ColW'(4);
    nr3 = ColW'(4);
    priority if (cnt3_q <= CountW'(2)) begin
      x3  = (idx3_q > 16'd1) ? PosW'(1) : PosW'(idx3_q[0]);
      y3  = x3;
      nc3 = ColW'(2);
      nr3 = ColW'(2);
    end else if (cnt3_q <= CountW'(4)) begin
      x3  = (idx3_q > 16'd3) ? PosW'(1) : PosW'(idx3_q[0]);
      y3  = (idx3_q > 16'd3) ? PosW'(1) : PosW'(idx3_q[1]);
      nc3 = ColW'(2);
      nr3 = ColW'(2);
    end else if (cnt3_q <= CountW'(8)) begin
      p3  = pat16((idx3_q > 16'd7) ? 4'd7 : idx3_q[3:0]);
      x3  = PosW'(p3[3:2]);
      y3  = PosW'(p3[1:0]);
    end else if (cnt3_q <= CountW'(16)) begin
      x3  = PosW'(p3[3:2]);
      y3  = PosW'(p3[1:0]);
    end else begin
      x3  = PosW'(gr);
      y3  = PosW'(gq);
      nc3 = cols3_q;
      nr3 = rows3_q;
    end
  end

  // ---- stages 4..8: carry the stratum beside the jitter mixers and dividers
  logic [PosW-1:0] x4_q, y4_q, x5_q, y5_q, x6_q, y6_q;
  logic [ColW-1:0] nc4_q, nr4_q, nc5_q, nr5_q, nc6_q, nr6_q, nc7_q, nr7_q;
  logic [ColW-1:0] nc8_q, nr8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x4_q <= x3;     y4_q <= y3;     nc4_q <= nc3;   nr4_q <= nr3;
      x5_q <= x4_q;   y5_q <= y4_q;   nc5_q <= nc4_q; nr5_q <= nr4_q;
      x6_q <= x5_q;   y6_q <= y5_q;   nc6_q <= nc5_q; nr6_q <= nr5_q;
      nc7_q <= nc6_q; nr7_q <= nr6_q;
      nc8_q <= nc7_q; nr8_q <= nr7_q;
    end
  end

  logic [31:0] ju, jv;

  sjs_mix u_mix_u (.clk_i, .en_i(en), .val_i(h_mix ^ USalt), .mix_o(ju));
  sjs_mix u_mix_v (.clk_i, .en_i(en), .val_i(h_mix ^ VSalt), .mix_o(jv));

  // ---- stage 6 comb: halved numerator x*2^24 + b (jitter) or + 2^23 (center)
  logic [DivNW-1:0] nu6, nv6, qu, qv;
  logic [ColW-1:0]  ru, rv;

  always_comb begin
    nu6 = DivNW'({x6_q, {FracBits{1'b0}}});
    nv6 = DivNW'({y6_q, {FracBits{1'b0}}});
    if (jit_q) begin
      nu6 = nu6 + DivNW'(ju[31:8]);
      nv6 = nv6 + DivNW'(jv[31:8]);
    end else begin
      nu6 = nu6 + DivNW'(CoordCenter);
      nv6 = nv6 + DivNW'(CoordCenter);
    end
  end

  sjs_div u_div_u (.clk_i, .en_i(en), .num_i(nu6), .den_i(nc6_q), .quo_o(qu), .rem_o(ru));
  sjs_div u_div_v (.clk_i, .en_i(en), .num_i(nv6), .den_i(nr6_q), .quo_o(qv), .rem_o(rv));

  // ---- stage 9: output register, clamp and single-sample center
  logic [FracBits-1:0] u_d, v_d, u_q, v_q;

  always_comb begin
    u_d = (qu > DivNW'(CoordMax)) ? CoordMax : FracBits'(qu);
    v_d = (qv > DivNW'(CoordMax)) ? CoordMax : FracBits'(qv);
    if (ctr_q[Depth-2]) begin
      u_d = CoordCenter;
      v_d = CoordCenter;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= u_d;
      v_q <= v_d;
    end
  end

  assign coord_u_o = u_q;
  assign coord_v_o = v_q;

  // remainders and last-stage divisors only feed checks
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7] && !ctr_q[7] |-> (ru < nc8_q) && (rv < nr8_q))
    else $error("divider remainder out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  a_center_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctr_q[Depth-1] |-> coord_u_o == CoordCenter && coord_v_o == CoordCenter)
    else $error("single sample not centered");

  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready decoupled from output slot");

endmodule

// File: tb/stratified_jitter_sample_2d_chk.sv
// Checker for the sample generator: predicts each result and compares it on transfer.
`timescale 1ns / 1ps
module stratified_jitter_sample_2d_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [31:0]                  base_seed_i,
  input  logic [15:0]                  sample_index_i,
  input  logic [sjs_pkg::CountW-1:0]   sample_count_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic                         cfg_jitter_enable_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [sjs_pkg::FracBits-1:0] coord_u_i,
  input  logic [sjs_pkg::FracBits-1:0] coord_v_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           results_seen_o
);

  typedef struct packed {
    logic [23:0] u;
    logic [23:0] v;
  } coord_t;

  coord_t coord_q[$];
  logic   jitter_q;

  assign pending_o = coord_q.size();

  function automatic logic [31:0] mix32(input logic [31:0] a);
    logic [31:0] w;
    w = a ^ (a >> 16);
    w = w * 32'h7FEB352D;
    w = w ^ (w >> 15);
    w = w * 32'h846CA68B;
    w = w ^ (w >> 16);
    return w;
  endfunction

  function automatic logic [23:0] offset(input int unsigned pos, input int unsigned div,
                                         input logic [31:0] hs, input logic jit);
    logic [63:0] num;
    logic [63:0] q;
    num = 64'(pos) << 25;
    if (jit) num += 2 * 64'(mix32(hs) >> 8) + 1;
    else num += 64'd1 << 24;
    q = num / (2 * 64'(div));
    return (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
  endfunction

  function automatic coord_t predict_coord(input logic [31:0] seed, input logic [15:0] idx,
                                           input logic [10:0] cnt_in, input logic jit);
    logic [31:0] h;
    int unsigned cnt, i, x, y, cols, rows;
    logic [3:0]  xy;
    coord_t r;
    cnt = cnt_in;
    if (cnt > 1024) cnt = 1024;
    if (cnt < 1) cnt = 1;
    h = 32'h9E3779B9;
    h ^= mix32(seed + 32'h85EBCA6B);
    h ^= mix32(32'(idx) + 32'hC2B2AE35);
    h ^= mix32(cnt + 32'h27D4EB2F);
    h ^= mix32(32'h165667B1);
    h = mix32(h);
    if (cnt == 1) begin
      r.u = 24'h80_0000;
      r.v = 24'h80_0000;
      return r;
    end
    if (cnt <= 4) begin
      i = (cnt == 2) ? ((idx > 1) ? 1 : idx) : ((idx > 3) ? 3 : idx);
      if (cnt == 2) begin
        x = i; y = i;
      end else begin
        x = i % 2; y = i / 2;
      end
      cols = 2; rows = 2;
    end else if (cnt <= 16) begin
      i = (cnt <= 8) ? ((idx > 7) ? 7 : idx) : ((idx > 15) ? 15 : idx);
      // interleaved 4x4 pattern: cells with even x+y first, then odd
      xy = {2'((i % 4) * 2 % 4 + (i / 4) % 2 + (i / 8) * 1), 2'(i / 2 % 4)};
      x = xy[3:2]; y = xy[1:0];
      case (i)
        0: begin x = 0; y = 0; end   1: begin x = 2; y = 0; end
        2: begin x = 1; y = 1; end   3: begin x = 3; y = 1; end
        4: begin x = 0; y = 2; end   5: begin x = 2; y = 2; end
        6: begin x = 1; y = 3; end   7: begin x = 3; y = 3; end
        8: begin x = 1; y = 0; end   9: begin x = 3; y = 0; end
        10: begin x = 0; y = 1; end  11: begin x = 2; y = 1; end
        12: begin x = 1; y = 2; end  13: begin x = 3; y = 2; end
        14: begin x = 0; y = 3; end  default: begin x = 2; y = 3; end
      endcase
      cols = 4; rows = 4;
    end else begin
      i = (idx > cnt - 1) ? cnt - 1 : idx;
      cols = 1;
      while (cols * cols < cnt) cols++;
      rows = (cnt + cols - 1) / cols;
      x = i % cols; y = i / cols;
    end
    r.u = offset(x, cols, h ^ 32'hA511E9B3, jit);
    r.v = offset(y, rows, h ^ 32'h63D83595, jit);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    coord_t exp_c;
    if (!rst_ni) begin
      jitter_q       <= 1'b0;
      fail_count_o   <= 0;
      results_seen_o <= 0;
      coord_q.delete();
    end else begin
      if (in_valid_i && in_ready_i)
        coord_q.push_back(predict_coord(base_seed_i, sample_index_i, sample_count_i, jitter_q));
      if (cfg_valid_i && cfg_ready_i) jitter_q <= cfg_jitter_enable_i;
      if (out_valid_i && out_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (coord_q.size() == 0) begin
          $error("result with nothing expected: u=%h v=%h", coord_u_i, coord_v_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = coord_q.pop_front();
          if (coord_u_i !== exp_c.u || coord_v_i !== exp_c.v) begin
            if (coord_u_i !== exp_c.u)
              $error("coord_u mismatch: expected %h actual %h", exp_c.u, coord_u_i);
            if (coord_v_i !== exp_c.v)
              $error("coord_v mismatch: expected %h actual %h", exp_c.v, coord_v_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/stratified_jitter_sample_2d_tb.sv
// Testbench top: drives stimulus and config, pairs the block with its checker.
`timescale 1ns / 1ps
module stratified_jitter_sample_2d_tb;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainDelay = 20;

  typedef enum int {
    PhFree, PhSendIdle, PhRecvStall, PhBoth
  } idle_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] base_seed_i = '0;
  logic [15:0] sample_index_i = '0;
  logic [10:0] sample_count_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_jitter_enable_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] coord_u_o;
  logic [23:0] coord_v_o;

  int          fail_count, pending, results_seen;
  idle_phase_e phase = PhFree;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  stratified_jitter_sample_2d DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .base_seed_i, .sample_index_i,
    .sample_count_i, .cfg_valid_i, .cfg_ready_o, .cfg_jitter_enable_i,
    .out_valid_o, .out_ready_i, .coord_u_o, .coord_v_o
  );

  stratified_jitter_sample_2d_chk u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .base_seed_i, .sample_index_i,
    .sample_count_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_jitter_enable_i,
    .out_valid_i(out_valid_o), .out_ready_i, .coord_u_i(coord_u_o), .coord_v_i(coord_v_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Receiver: stall per the current phase, redrawn every edge.
  always @(posedge clk_i) begin
    case (phase)
      PhRecvStall: out_ready_i <= ($urandom_range(99) >= 80);
      PhBoth:      out_ready_i <= ($urandom_range(99) >= 25);
      default:     out_ready_i <= 1'b1;
    endcase
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one item, hold it until transfer; gap before it per phase.
  task automatic send_sample(input logic [31:0] seed, input logic [15:0] idx,
                             input logic [10:0] cnt);
    int unsigned gap_pct;
    gap_pct = (phase == PhSendIdle) ? 80 : (phase == PhBoth) ? 25 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    base_seed_i    <= seed;
    sample_index_i <= idx;
    sample_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Drain outstanding results, let the pipe settle, then write the register.
  task automatic write_jitter(input logic en);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainDelay) @(posedge clk_i);
    cfg_valid_i         <= 1'b1;
    cfg_jitter_enable_i <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random(input int unsigned n);
    logic [10:0] cnt;
    logic [15:0] idx;
    repeat (n) begin
      case ($urandom_range(9))
        0:       cnt = 11'($urandom_range(2047));         // includes above-bound counts
        1, 2:    cnt = 11'($urandom_range(16));
        3:       cnt = 11'($urandom_range(1024, 1000));
        default: cnt = 11'($urandom_range(1024, 17));
      endcase
      // mostly in-range indices, sometimes anything
      if ($urandom_range(3) == 0) idx = 16'($urandom);
      else idx = 16'($urandom_range((cnt == 0) ? 0 : cnt - 1));
      send_sample($urandom, idx, cnt);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: centers, each table size, clamped indices, count extremes.
    send_sample(32'h0, 16'h0, 11'd0);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 11'd1);
    send_sample(32'h1234_5678, 16'd1, 11'd2);
    send_sample(32'h1234_5678, 16'd9, 11'd2);
    send_sample(32'hA5A5_A5A5, 16'd3, 11'd4);
    send_sample(32'h5A5A_5A5A, 16'd7, 11'd3);
    send_sample(32'h0, 16'd6, 11'd8);
    send_sample(32'h1, 16'd12, 11'd5);
    send_sample(32'h2, 16'd15, 11'd16);
    send_sample(32'h3, 16'd40, 11'd9);
    send_sample(32'h4, 16'd16, 11'd17);
    send_sample(32'h5, 16'hFFFF, 11'd1024);
    send_sample(32'h6, 16'd1023, 11'd1024);
    send_sample(32'h7, 16'd500, 11'd1025);
    send_sample(32'h8, 16'd3000, 11'd2047);
    write_jitter(1'b1);
    send_sample(32'hFFFF_FFFF, 16'hFFFF, 11'd0);
    send_sample(32'hDEAD_BEEF, 16'd1, 11'd2);
    send_sample(32'hCAFE_F00D, 16'd2, 11'd4);
    send_sample(32'h0, 16'd7, 11'd8);
    send_sample(32'h1, 16'd15, 11'd16);
    send_sample(32'h2, 16'd1023, 11'd1024);
    send_sample(32'h3, 16'hFFFF, 11'd2047);

    // Random phases with alternating register settings.
    phase = PhFree;      send_random(130);
    write_jitter(1'b0);
    phase = PhSendIdle;  send_random(110);
    phase = PhRecvStall; send_random(110);
    write_jitter(1'b1);
    phase = PhBoth;      send_random(130);
    phase = PhFree;      send_random(20);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainDelay) @(posedge clk_i);
    $display("covered %0d samples, %0d results; counts 0..2047, both jitter modes",
             items_sent, results_seen);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
